[design/sdtw_pkg.sv]
// Shared types and constants for the short-descriptor table walk.
package sdtw_pkg;

    // Defaults and fixed field widths
    localparam int VA_BITS_DEF = 24;
    localparam int DESC_W      = 32;
    localparam int PHYS_W      = 39;
    localparam int L1_SHIFT    = 20;
    localparam int L2_SHIFT    = 12;
    localparam int QUEUE_DEPTH = 2;

    // Request operation codes
    localparam logic [1:0] OP_WR_L1 = 2'd0;
    localparam logic [1:0] OP_WR_L2 = 2'd1;
    localparam logic [1:0] OP_XLATE = 2'd2;

    // Response status codes
    localparam logic [1:0] ST_MAPPED   = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_RESERVED = 2'd2;

    // First-level descriptor types
    localparam logic [1:0] D1_FAULT   = 2'd0;
    localparam logic [1:0] D1_COARSE  = 2'd1;
    localparam logic [1:0] D1_SECTION = 2'd2;
    localparam logic [1:0] D1_RSVD    = 2'd3;

    // Second-level descriptor types (small page covers both upper codes)
    localparam logic [1:0] D2_FAULT   = 2'd0;
    localparam logic [1:0] D2_LARGE   = 2'd1;

    // Supersection flag position in a section descriptor
    localparam int SUPER_BIT = 18;

    // Mapping sizes, log2
    localparam logic [4:0] SZ_SMALL   = 5'd12;
    localparam logic [4:0] SZ_LARGE   = 5'd16;
    localparam logic [4:0] SZ_SECTION = 5'd20;
    localparam logic [4:0] SZ_SUPER   = 5'd24;

    // Command queued between front and back
    typedef enum logic [1:0] {
        CMD_WR_L1,
        CMD_WR_L2,
        CMD_XLATE
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_DECODE
    } back_state_t;

    // One translation response
    typedef struct packed {
        logic [1:0]        status;
        logic [4:0]        page_size_log2;
        logic [PHYS_W-1:0] phys_addr;
        logic [2:0]        domain;
        logic              executable;
        logic              global_page;
        logic              shared;
    } rsp_t;

endpackage

[design/sdtw_front.sv]
// Request front end: accepts requests and classifies them into queue commands.
module sdtw_front #(
    parameter int VA_BITS = sdtw_pkg::VA_BITS_DEF
) (
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [1:0]                  operation,
    input  logic [VA_BITS-1:0]          virt_addr,
    input  logic [sdtw_pkg::DESC_W-1:0] descriptor,
    input  logic                        clear_busy,
    input  logic                        q_space,
    output logic                        q_push,
    output sdtw_pkg::cmd_t              q_kind,
    output logic [VA_BITS-1:0]          q_va,
    output logic [sdtw_pkg::DESC_W-1:0] q_desc
);

    logic known_op;

    // Hold requests off while the tables are being cleared or the queue is full
    assign req_ready = !clear_busy && q_space;

    // Operation decode; the unused code is taken and dropped
    always_comb
    begin
        known_op = 1'b1;
        q_kind   = sdtw_pkg::CMD_XLATE;
        unique case (operation)
            sdtw_pkg::OP_WR_L1: q_kind = sdtw_pkg::CMD_WR_L1;
            sdtw_pkg::OP_WR_L2: q_kind = sdtw_pkg::CMD_WR_L2;
            sdtw_pkg::OP_XLATE: q_kind = sdtw_pkg::CMD_XLATE;
            default:            known_op = 1'b0;
        endcase
    end

    assign q_push = req_valid && req_ready && known_op;
    assign q_va   = virt_addr;
    assign q_desc = descriptor;

endmodule

[design/sdtw_queue.sv]
// Short command queue between the front end and the table back end.
module sdtw_queue #(
    parameter int VA_BITS = sdtw_pkg::VA_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  sdtw_pkg::cmd_t              push_kind,
    input  logic [VA_BITS-1:0]          push_va,
    input  logic [sdtw_pkg::DESC_W-1:0] push_desc,
    output logic                        space,
    input  logic                        pop,
    output logic                        head_valid,
    output sdtw_pkg::cmd_t              head_kind,
    output logic [VA_BITS-1:0]          head_va,
    output logic [sdtw_pkg::DESC_W-1:0] head_desc
);

    localparam int DEPTH = sdtw_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sdtw_pkg::cmd_t              kind_q [DEPTH];
    logic [VA_BITS-1:0]          va_q   [DEPTH];
    logic [sdtw_pkg::DESC_W-1:0] desc_q [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign space      = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign do_push    = push && space;
    assign do_pop     = pop && head_valid;

    assign head_kind = kind_q[rd_ptr_reg];
    assign head_va   = va_q[rd_ptr_reg];
    assign head_desc = desc_q[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            kind_q[wr_ptr_reg] <= push_kind;
            va_q[wr_ptr_reg]   <= push_va;
            desc_q[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[design/sdtw_back.sv]
// Table back end: descriptor memories, clearing pass, walk sequencer and response register.
module sdtw_back #(
    parameter int VA_BITS = sdtw_pkg::VA_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  sdtw_pkg::cmd_t              q_kind,
    input  logic [VA_BITS-1:0]          q_va,
    input  logic [sdtw_pkg::DESC_W-1:0] q_desc,
    output logic                        clear_busy,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output sdtw_pkg::rsp_t              rsp_data
);

    localparam int L1_AW = VA_BITS - sdtw_pkg::L1_SHIFT;
    localparam int L2_AW = VA_BITS - sdtw_pkg::L2_SHIFT;
    localparam int DW    = sdtw_pkg::DESC_W;

    logic [DW-1:0] l1_mem [2**L1_AW];
    logic [DW-1:0] l2_mem [2**L2_AW];

    sdtw_pkg::back_state_t state_reg, state_next;
    logic [L2_AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    sdtw_pkg::rsp_t        rsp_reg, rsp_next;

    logic             l1_we, l2_we, rd_en;
    logic [L1_AW-1:0] l1_waddr, l1_raddr;
    logic [L2_AW-1:0] l2_waddr, l2_raddr;
    logic [DW-1:0]    l1_wdata, l2_wdata;
    logic [DW-1:0]    l1_rdata_reg, l2_rdata_reg;
    logic             slot_free;

    // Descriptor decode for one walk
    function automatic sdtw_pkg::rsp_t walk_decode(input logic [DW-1:0] d1,
                                                   input logic [DW-1:0] d2);
        sdtw_pkg::rsp_t r;
        r.status         = sdtw_pkg::ST_UNMAPPED;
        r.page_size_log2 = sdtw_pkg::SZ_SECTION;
        r.phys_addr      = '0;
        r.domain         = '0;
        r.executable     = 1'b1;
        r.global_page    = 1'b0;
        r.shared         = 1'b0;
        unique case (d1[1:0])
            sdtw_pkg::D1_FAULT:
            begin
                r.status = sdtw_pkg::ST_UNMAPPED;
            end
            sdtw_pkg::D1_COARSE:
            begin
                r.domain = d1[7:5];
                unique case (d2[1:0])
                    sdtw_pkg::D2_FAULT:
                    begin
                        r.status         = sdtw_pkg::ST_UNMAPPED;
                        r.page_size_log2 = sdtw_pkg::SZ_SMALL;
                    end
                    sdtw_pkg::D2_LARGE:
                    begin
                        r.status         = sdtw_pkg::ST_MAPPED;
                        r.page_size_log2 = sdtw_pkg::SZ_LARGE;
                        r.phys_addr      = {7'b0, d2[31:16], 16'b0};
                    end
                    default:
                    begin
                        // small page, XN in bit 0, nG in bit 11, S in bit 10
                        r.status         = sdtw_pkg::ST_MAPPED;
                        r.page_size_log2 = sdtw_pkg::SZ_SMALL;
                        r.phys_addr      = {7'b0, d2[31:12], 12'b0};
                        r.executable     = !d2[0];
                        r.global_page    = !d2[11];
                        r.shared         = d2[10];
                    end
                endcase
            end
            sdtw_pkg::D1_SECTION:
            begin
                r.status = sdtw_pkg::ST_MAPPED;
                if (d1[sdtw_pkg::SUPER_BIT])
                begin
                    // supersection: extended base bits from 23:20 and 7:5
                    r.page_size_log2 = sdtw_pkg::SZ_SUPER;
                    r.phys_addr      = {d1[7:5], d1[23:20], d1[31:24], 24'b0};
                end
                else
                begin
                    r.page_size_log2 = sdtw_pkg::SZ_SECTION;
                    r.phys_addr      = {7'b0, d1[31:20], 20'b0};
                    r.domain         = d1[7:5];
                end
            end
            default:
            begin
                r.status = sdtw_pkg::ST_RESERVED;
            end
        endcase
        return r;
    endfunction

    assign slot_free  = !rsp_valid_reg || rsp_ready;
    assign clear_busy = (state_reg == sdtw_pkg::BK_CLEAR);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_reg;

    // Table addresses come straight from the queue head
    assign l1_raddr = q_va[VA_BITS-1:sdtw_pkg::L1_SHIFT];
    assign l2_raddr = q_va[VA_BITS-1:sdtw_pkg::L2_SHIFT];

    // Sequencer: clearing pass, command dispatch, decode into response slot
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        l1_we          = 1'b0;
        l2_we          = 1'b0;
        l1_waddr       = l1_raddr;
        l2_waddr       = l2_raddr;
        l1_wdata       = q_desc;
        l2_wdata       = q_desc;
        unique case (state_reg)
            sdtw_pkg::BK_CLEAR:
            begin
                l1_we        = 1'b1;
                l2_we        = 1'b1;
                l1_waddr     = clr_cnt_reg[L1_AW-1:0];
                l2_waddr     = clr_cnt_reg;
                l1_wdata     = '0;
                l2_wdata     = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = sdtw_pkg::BK_IDLE;
                end
            end
            sdtw_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_kind)
                        sdtw_pkg::CMD_WR_L1: l1_we = 1'b1;
                        sdtw_pkg::CMD_WR_L2: l2_we = 1'b1;
                        sdtw_pkg::CMD_XLATE:
                        begin
                            rd_en      = 1'b1;
                            state_next = sdtw_pkg::BK_DECODE;
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            sdtw_pkg::BK_DECODE:
            begin
                if (slot_free)
                begin
                    rsp_next       = walk_decode(l1_rdata_reg, l2_rdata_reg);
                    rsp_valid_next = 1'b1;
                    state_next     = sdtw_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = sdtw_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdtw_pkg::BK_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // First-level table, registered read
    always_ff @(posedge clk)
    begin
        if (l1_we)
        begin
            l1_mem[l1_waddr] <= l1_wdata;
        end
        if (rd_en)
        begin
            l1_rdata_reg <= l1_mem[l1_raddr];
        end
    end

    // Second-level table, registered read
    always_ff @(posedge clk)
    begin
        if (l2_we)
        begin
            l2_mem[l2_waddr] <= l2_wdata;
        end
        if (rd_en)
        begin
            l2_rdata_reg <= l2_mem[l2_raddr];
        end
    end

endmodule

[design/short_descriptor_table_walk.sv]
// Top level of the short-descriptor page table walk.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------------------
//   request  | in        | req_valid/req_ready  | operation, virt_addr, descriptor
//   response | out       | rsp_valid/rsp_ready  | status, page_size_log2, phys_addr,
//            |           |                      | domain, executable, global_page, shared
//
// A table write is done by the back end as it pops the command; a translation first reads
// both tables from synchronous memory, then decodes into the response register.
// rsp_valid rises after the request passes the queue, the table reads and the decode state.
// After reset a clearing pass zeroes both tables over all 2**(VA_BITS-12) second-level entries
// (4096 at the default width); req_ready stays low throughout.
// A two-entry command queue lets requests be taken while a response waits to be taken.
module short_descriptor_table_walk #(
    parameter int VA_BITS = sdtw_pkg::VA_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [1:0]                    operation,
    input  logic [VA_BITS-1:0]            virt_addr,
    input  logic [sdtw_pkg::DESC_W-1:0]   descriptor,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [1:0]                    status,
    output logic [4:0]                    page_size_log2,
    output logic [sdtw_pkg::PHYS_W-1:0]   phys_addr,
    output logic [2:0]                    domain,
    output logic                          executable,
    output logic                          global_page,
    output logic                          shared
);

    logic                        clear_busy;
    logic                        q_space, q_push, q_pop, q_valid;
    sdtw_pkg::cmd_t              push_kind, head_kind;
    logic [VA_BITS-1:0]          push_va, head_va;
    logic [sdtw_pkg::DESC_W-1:0] push_desc, head_desc;
    sdtw_pkg::rsp_t              rsp_data;

    sdtw_front #(
        .VA_BITS (VA_BITS)
    ) u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .operation  (operation),
        .virt_addr  (virt_addr),
        .descriptor (descriptor),
        .clear_busy (clear_busy),
        .q_space    (q_space),
        .q_push     (q_push),
        .q_kind     (push_kind),
        .q_va       (push_va),
        .q_desc     (push_desc)
    );

    sdtw_queue #(
        .VA_BITS (VA_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_kind  (push_kind),
        .push_va    (push_va),
        .push_desc  (push_desc),
        .space      (q_space),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_kind  (head_kind),
        .head_va    (head_va),
        .head_desc  (head_desc)
    );

    sdtw_back #(
        .VA_BITS (VA_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_kind     (head_kind),
        .q_va       (head_va),
        .q_desc     (head_desc),
        .clear_busy (clear_busy),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data)
    );

    // Response fields
    assign status         = rsp_data.status;
    assign page_size_log2 = rsp_data.page_size_log2;
    assign phys_addr      = rsp_data.phys_addr;
    assign domain         = rsp_data.domain;
    assign executable     = rsp_data.executable;
    assign global_page    = rsp_data.global_page;
    assign shared         = rsp_data.shared;

endmodule

[design/sdtw_checker.sv]
// Port-level checks for the short-descriptor table walk, bound to the top level.
module sdtw_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [1:0]                  status,
    input logic [4:0]                  page_size_log2,
    input logic [sdtw_pkg::PHYS_W-1:0] phys_addr,
    input logic [2:0]                  domain,
    input logic                        executable,
    input logic                        global_page,
    input logic                        shared
);

    // A stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(page_size_log2) && $stable(phys_addr) && $stable(domain)
            && $stable(executable) && $stable(global_page) && $stable(shared))
        else $error("response changed while stalled");

    // Tables are still being cleared on the first cycle out of reset
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !req_ready)
        else $error("request taken during table clearing");

    // Reserved descriptors carry no base and no domain
    a_reserved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == sdtw_pkg::ST_RESERVED |->
            phys_addr == '0 && domain == '0
            && page_size_log2 == sdtw_pkg::SZ_SECTION)
        else $error("reserved response with base or domain");

    // Only a supersection reaches above 32 address bits, and it has no domain
    a_ext_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && phys_addr[sdtw_pkg::PHYS_W-1:32] != '0 |->
            page_size_log2 == sdtw_pkg::SZ_SUPER && domain == '0)
        else $error("extended address bits outside a supersection");

    // Small-page attributes appear only on mapped small pages
    a_attr_small: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (!executable || global_page || shared) |->
            status == sdtw_pkg::ST_MAPPED && page_size_log2 == sdtw_pkg::SZ_SMALL)
        else $error("page attributes on a non small page response");

endmodule

bind short_descriptor_table_walk sdtw_checker u_sdtw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_ready      (req_ready),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .status         (status),
    .page_size_log2 (page_size_log2),
    .phys_addr      (phys_addr),
    .domain         (domain),
    .executable     (executable),
    .global_page    (global_page),
    .shared         (shared)
);
